FILE: hw/rtl/dwmes_pkg.sv
package dwmes_pkg;

	// APB register window
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Q1.16 level of 1.0
	localparam logic [16:0] LEVEL_ONE = 17'h10000;

	// mix policy codes
	localparam logic [1:0] POL_OFF   = 2'd0;
	localparam logic [1:0] POL_EXACT = 2'd1;

	// register reset values
	localparam logic [1:0]  RST_MIX_POLICY  = POL_EXACT;
	localparam logic [18:0] RST_FS_HZ       = 19'd48000;

	// rate / 1000 as multiply by ceil(2^29 / 1000), exact for 19-bit rates
	localparam logic [19:0] SR_RCP   = 20'd536871;
	localparam int          SR_SHIFT = 29;
	localparam int          SR_Q_W   = 10;
	localparam int          MIN_FADE = 8;

	// register map, index = byte address / 4
	typedef enum logic [2:0] {
		REG_MIX_LEVEL,
		REG_MIX_POLICY,
		REG_FRAME_COUNT,
		REG_DRY_FRAME_COUNT,
		REG_FS_HZ,
		REG_SPLICE_EDGES,
		REG_HEAD_EDGE,
		REG_TAIL_EDGE
	} reg_idx_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK,
		STAT_MIX_OFF,
		STAT_LEN_MISMATCH
	} status_t;

	// source of the pre-splice sample
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_DRY,
		SEL_WET,
		SEL_MIX
	} mix_sel_t;

endpackage

FILE: hw/rtl/dry_wet_mix_edge_splice_core.sv
// Dry/wet crossfade with head/tail edge splice, six-stage pipeline.
// Throughput: one request per cycle while result_ready is high; the stage count fixes latency, not rate.
// Each stage holds its request while the next one is full, so a stall drops nothing.
// Reset (arst_n low, async) empties the pipeline and loads register defaults:
// mix_level 1.0, policy exact, frame counts 0, 48 kHz, no splice, edges 0.
module dry_wet_mix_edge_splice_core
	import dwmes_pkg::*;
#(
	parameter int FRAME_BITS = 24,
	parameter int MAX_FADE   = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_W-1:0]            paddr,
	input  logic [DATA_W-1:0]            pwdata,
	output logic [DATA_W-1:0]            prdata,
	output logic                         pready,
	// request channel
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic signed [15:0]           dry_sample,
	input  logic signed [15:0]           wet_sample,
	input  logic [FRAME_BITS-1:0]        frame_index,
	// result channel
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic signed [15:0]           out_sample,
	output logic [1:0]                   status
);

	localparam int FW   = $clog2(MAX_FADE + 1);          // fade length
	localparam int DW   = $clog2(MAX_FADE + 2);          // divisor f+1
	localparam int CW   = (FRAME_BITS > FW) ? FRAME_BITS : FW;
	localparam int PW   = DW + 17;                       // splice partial products
	localparam int NUMW = DW + 18;                       // splice numerator
	localparam int S    = DW + 18;                       // dividend width and shift
	localparam int RW   = S - 1;                         // reciprocal width
	localparam int EW   = 18;                            // quotient estimate

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [16:0]           mix_level_q;
	logic [1:0]            mix_policy_q;
	logic [FRAME_BITS-1:0] frame_count_q;
	logic [FRAME_BITS-1:0] dry_frame_count_q;
	logic [18:0]           fs_hz_q;
	logic [1:0]            splice_edges_q;
	logic [15:0]           head_edge_q;
	logic [15:0]           tail_edge_q;
	logic                  cfg_wr;
	reg_idx_t              cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_level_q       <= LEVEL_ONE;
			mix_policy_q      <= RST_MIX_POLICY;
			frame_count_q     <= '0;
			dry_frame_count_q <= '0;
			fs_hz_q           <= RST_FS_HZ;
			splice_edges_q    <= '0;
			head_edge_q       <= '0;
			tail_edge_q       <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MIX_LEVEL:       mix_level_q       <= pwdata[16:0];
				REG_MIX_POLICY:      mix_policy_q      <= pwdata[1:0];
				REG_FRAME_COUNT:     frame_count_q     <= pwdata[FRAME_BITS-1:0];
				REG_DRY_FRAME_COUNT: dry_frame_count_q <= pwdata[FRAME_BITS-1:0];
				REG_FS_HZ:           fs_hz_q           <= pwdata[18:0];
				REG_SPLICE_EDGES:    splice_edges_q    <= pwdata[1:0];
				REG_HEAD_EDGE:       head_edge_q       <= pwdata[15:0];
				REG_TAIL_EDGE:       tail_edge_q       <= pwdata[15:0];
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (cfg_idx)
			REG_MIX_LEVEL:       prdata = DATA_W'(mix_level_q);
			REG_MIX_POLICY:      prdata = DATA_W'(mix_policy_q);
			REG_FRAME_COUNT:     prdata = DATA_W'(frame_count_q);
			REG_DRY_FRAME_COUNT: prdata = DATA_W'(dry_frame_count_q);
			REG_FS_HZ:           prdata = DATA_W'(fs_hz_q);
			REG_SPLICE_EDGES:    prdata = DATA_W'(splice_edges_q);
			REG_HEAD_EDGE:       prdata = DATA_W'(head_edge_q);
			REG_TAIL_EDGE:       prdata = DATA_W'(tail_edge_q);
		endcase
	end

	// saturate to Q1.15
	function automatic logic [15:0] sat16(input logic signed [35:0] v);
		if (v > 36'sd32767)
			return 16'h7fff;
		else if (v < -36'sd32768)
			return 16'h8000;
		else
			return v[15:0];
	endfunction

	// reciprocal table: ceil(2^S / (2*d)) for divisor d = f+1
	logic [RW-1:0] rcp_tab [MAX_FADE+2];
	for (genvar g = 0; g < MAX_FADE + 2; g++) begin : g_rcp
		localparam longint unsigned DEN = (g < 2) ? 64'd4 : 64'(2 * g);
		localparam longint unsigned RV  = ((64'd1 << S) + DEN - 64'd1) / DEN;
		assign rcp_tab[g] = RV[RW-1:0];
	end

	// ------------------------------------------------------------------
	// pipeline handshake: a stage loads when empty or when it drains
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	assign rdy_s6 = !v_s6 || result_ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign item_ready   = rdy_s1;
	assign result_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= item_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: policy check, mix products, fade length product
	// ------------------------------------------------------------------
	logic [16:0]           m_lvl;
	mix_sel_t              sel_c1;
	status_t               stat_c1;
	logic                  splice_c1;
	logic signed [33:0]    p_dry_c1, p_wet_c1;
	logic [38:0]           sr_prod_c1;
	logic [FRAME_BITS-1:0] ktail_c1;

	always_comb begin
		m_lvl   = (mix_level_q > LEVEL_ONE) ? LEVEL_ONE : mix_level_q;
		sel_c1  = SEL_MIX;
		stat_c1 = STAT_OK;
		if (mix_policy_q == POL_OFF && m_lvl != LEVEL_ONE) begin
			stat_c1 = STAT_MIX_OFF;
			sel_c1  = SEL_ZERO;
		end else if (m_lvl == '0) begin
			sel_c1 = SEL_DRY;
		end else if (m_lvl == LEVEL_ONE) begin
			sel_c1 = SEL_WET;
		end else if (mix_policy_q != POL_EXACT || frame_count_q != dry_frame_count_q) begin
			stat_c1 = STAT_LEN_MISMATCH;
			sel_c1  = SEL_ZERO;
		end
		splice_c1 = (stat_c1 == STAT_OK) && (m_lvl != '0) &&
			(frame_count_q >= FRAME_BITS'(2));
	end

	assign p_dry_c1   = dry_sample * $signed({1'b0, LEVEL_ONE - m_lvl});
	assign p_wet_c1   = wet_sample * $signed({1'b0, m_lvl});
	assign sr_prod_c1 = 39'(fs_hz_q) * 39'(SR_RCP);
	assign ktail_c1   = frame_count_q - FRAME_BITS'(1) - frame_index;

	logic signed [15:0]    dry_s1, wet_s1;
	mix_sel_t              sel_s1;
	status_t               stat_s1;
	logic                  splice_s1;
	logic signed [33:0]    p_dry_s1, p_wet_s1;
	logic [SR_Q_W-1:0]     fq_s1;
	logic [FRAME_BITS-1:0] idx_s1, ktail_s1;
	logic                  inreg_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && item_valid) begin
			dry_s1    <= dry_sample;
			wet_s1    <= wet_sample;
			sel_s1    <= sel_c1;
			stat_s1   <= stat_c1;
			splice_s1 <= splice_c1;
			p_dry_s1  <= p_dry_c1;
			p_wet_s1  <= p_wet_c1;
			fq_s1     <= sr_prod_c1[SR_SHIFT+SR_Q_W-1:SR_SHIFT];
			idx_s1    <= frame_index;
			ktail_s1  <= ktail_c1;
			inreg_s1  <= frame_index < frame_count_q;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: mix sum with rounding, fade length clamp
	// ------------------------------------------------------------------
	logic signed [34:0]    sum_c2, shr_c2;
	logic [15:0]           y_c2;
	logic [FW-1:0]         fc_c2, f_c2;
	logic [FRAME_BITS-1:0] half_c2;

	always_comb begin
		sum_c2 = 35'(p_dry_s1) + 35'(p_wet_s1) + 35'sd32768;
		shr_c2 = sum_c2 >>> 16;
		case (sel_s1)
			SEL_DRY: y_c2 = dry_s1;
			SEL_WET: y_c2 = wet_s1;
			SEL_MIX: y_c2 = sat16(36'(shr_c2));
			default: y_c2 = '0;
		endcase

		// F = clamp(rate/1000, 8, MAX_FADE), then at most frames/2
		if (fq_s1 < SR_Q_W'(MIN_FADE))
			fc_c2 = FW'(MIN_FADE);
		else if (fq_s1 > SR_Q_W'(MAX_FADE))
			fc_c2 = FW'(MAX_FADE);
		else
			fc_c2 = FW'(fq_s1);
		half_c2 = frame_count_q >> 1;
		f_c2    = (CW'(half_c2) < CW'(fc_c2)) ? FW'(half_c2) : fc_c2;
	end

	logic [15:0]           y_s2;
	status_t               stat_s2;
	logic                  splice_s2;
	logic [FW-1:0]         f_s2;
	logic [FRAME_BITS-1:0] idx_s2, ktail_s2;
	logic                  inreg_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			y_s2      <= y_c2;
			stat_s2   <= stat_s1;
			splice_s2 <= splice_s1;
			f_s2      <= f_c2;
			idx_s2    <= idx_s1;
			ktail_s2  <= ktail_s1;
			inreg_s2  <= inreg_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: edge select and weighted products
	// head and tail windows never overlap since F <= frames/2
	// ------------------------------------------------------------------
	logic                 head_c3, tail_c3;
	logic [CW-1:0]        kx_c3;
	logic [DW-1:0]        wa_c3, wb_c3, d_c3;
	logic signed [15:0]   edge_c3;
	logic signed [PW-1:0] pa_c3, pb_c3;

	always_comb begin
		head_c3 = splice_edges_q[0] && (CW'(idx_s2) < CW'(f_s2));
		tail_c3 = splice_edges_q[1] && inreg_s2 && (CW'(ktail_s2) < CW'(f_s2));
		kx_c3   = head_c3 ? CW'(idx_s2) : CW'(ktail_s2);
		edge_c3 = head_c3 ? $signed(head_edge_q) : $signed(tail_edge_q);
		wa_c3   = DW'(f_s2) - DW'(kx_c3[FW-1:0]);
		wb_c3   = DW'(kx_c3[FW-1:0]) + DW'(1);
		d_c3    = DW'(f_s2) + DW'(1);
	end

	assign pa_c3 = edge_c3 * $signed({1'b0, wa_c3});
	assign pb_c3 = $signed(y_s2) * $signed({1'b0, wb_c3});

	logic signed [PW-1:0] pa_s3, pb_s3;
	logic [DW-1:0]        d_s3;
	logic [RW-1:0]        rcp_s3;
	logic                 apply_s3;
	logic [15:0]          y_s3;
	status_t              stat_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			pa_s3    <= pa_c3;
			pb_s3    <= pb_c3;
			d_s3     <= d_c3;
			rcp_s3   <= rcp_tab[d_c3];
			apply_s3 <= splice_s2 && (head_c3 || tail_c3);
			y_s3     <= y_s2;
			stat_s3  <= stat_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: numerator, biased positive, doubled for round-half-up
	// n2 = 2*(num + 32768*d) + d, quotient = n2 / (2d)
	// ------------------------------------------------------------------
	logic signed [NUMW-1:0] pos_c4;
	logic [S-1:0]           n2_c4;

	always_comb begin
		pos_c4 = NUMW'(pa_s3) + NUMW'(pb_s3) + $signed({3'b000, d_s3, 15'b0});
		n2_c4  = S'({pos_c4[DW+15:0], 1'b0}) + S'(d_s3);
	end

	logic [S-1:0]  n2_s4;
	logic [DW-1:0] d_s4;
	logic [RW-1:0] rcp_s4;
	logic          apply_s4;
	logic [15:0]   y_s4;
	status_t       stat_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			n2_s4    <= n2_c4;
			d_s4     <= d_s3;
			rcp_s4   <= rcp_s3;
			apply_s4 <= apply_s3;
			y_s4     <= y_s3;
			stat_s4  <= stat_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 5: reciprocal multiply, estimate is exact or one high
	// ------------------------------------------------------------------
	logic [S+RW-1:0] qprod_c5;

	assign qprod_c5 = (S+RW)'(n2_s4) * (S+RW)'(rcp_s4);

	logic [EW-1:0] est_s5;
	logic [S-1:0]  n2_s5;
	logic [DW-1:0] d_s5;
	logic          apply_s5;
	logic [15:0]   y_s5;
	status_t       stat_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			est_s5   <= qprod_c5[S+EW-1:S];
			n2_s5    <= n2_s4;
			d_s5     <= d_s4;
			apply_s5 <= apply_s4;
			y_s5     <= y_s4;
			stat_s5  <= stat_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 6: quotient correction, unbias, saturate; output register
	// ------------------------------------------------------------------
	logic [S:0]           chk_c6;
	logic [EW-1:0]        q_c6;
	logic signed [EW:0]   res_c6;
	logic [15:0]          fin_c6;

	always_comb begin
		chk_c6 = (S+1)'(est_s5) * (S+1)'({d_s5, 1'b0});
		q_c6   = (chk_c6 > (S+1)'(n2_s5)) ? est_s5 - EW'(1) : est_s5;
		res_c6 = $signed({1'b0, q_c6}) - (EW+1)'(32768);
		fin_c6 = apply_s5 ? sat16(36'(res_c6)) : y_s5;
	end

	logic [15:0] out_sample_s6;
	status_t     status_s6;

	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			out_sample_s6 <= fin_c6;
			status_s6     <= stat_s5;
		end
	end

	assign out_sample = $signed(out_sample_s6);
	assign status     = status_s6;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// an error status always comes with a zero sample
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && status_s6 != STAT_OK |-> out_sample_s6 == '0)
		else $error("error status with nonzero sample");

	// splice is only armed on requests that passed the policy check
	a_splice_ok: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && apply_s3 |-> stat_s3 == STAT_OK && d_s3 >= DW'(2))
		else $error("splice armed on bad request");

	// reciprocal estimate is never more than one above the true quotient
	a_est_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && apply_s5 |->
			(S+1)'(est_s5) * (S+1)'({d_s5, 1'b0}) <= (S+1)'(n2_s5) + (S+1)'({d_s5, 1'b0}))
		else $error("quotient estimate out of range");

	// a blocked stage keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy_s2 |=> v_s1 && $stable(y_c2) && $stable(stat_s1))
		else $error("stage 1 lost a request under stall");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import dwmes_pkg::*;

	localparam int LATENCY        = 6;
	localparam int FADE_CAP       = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 1625;
	localparam int LONG_HOLD      = 150;

	// one expected output request
	typedef struct {
		logic signed [15:0] sample;
		status_t            st;
	} mix_result_t;

	// register shadow, output prediction and in-order compare
	class splice_scoreboard;
		logic [16:0]        level;
		logic [1:0]         policy;
		logic [23:0]        frames;
		logic [23:0]        dry_frames;
		logic [18:0]        rate;
		logic [1:0]         edges;
		logic signed [15:0] head;
		logic signed [15:0] tail;
		mix_result_t        expected_mix[$];
		int                 errors;

		function new();
			level      = LEVEL_ONE;
			policy     = RST_MIX_POLICY;
			frames     = '0;
			dry_frames = '0;
			rate       = RST_FS_HZ;
			edges      = '0;
			head       = '0;
			tail       = '0;
			errors     = 0;
		endfunction

		function void write_reg(reg_idx_t r, logic [31:0] v);
			case (r)
				REG_MIX_LEVEL:       level      = v[16:0];
				REG_MIX_POLICY:      policy     = v[1:0];
				REG_FRAME_COUNT:     frames     = v[23:0];
				REG_DRY_FRAME_COUNT: dry_frames = v[23:0];
				REG_FS_HZ:           rate       = v[18:0];
				REG_SPLICE_EDGES:    edges      = v[1:0];
				REG_HEAD_EDGE:       head       = v[15:0];
				REG_TAIL_EDGE:       tail       = v[15:0];
				default:             ;
			endcase
		endfunction

		function longint sat16(longint v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return v;
		endfunction

		// (e*(f-k) + x*(k+1)) / (f+1), nearest, ties up
		function longint edge_fade(longint e, longint x, longint k, longint f);
			longint d;
			longint pos;
			d   = f + 1;
			pos = e * (f - k) + x * (k + 1) + 32768 * d;
			return sat16((pos * 2 + d) / (2 * d) - 32768);
		endfunction

		function mix_result_t mix_splice(logic signed [15:0] dry, logic signed [15:0] wet,
				logic [23:0] idx);
			mix_result_t r;
			longint m;
			longint s;
			longint y;
			longint f;
			longint k;
			r.st = STAT_OK;
			y = 0;
			m = (level > LEVEL_ONE) ? longint'(LEVEL_ONE) : longint'(level);
			// policy and level decide the pre-splice sample
			if (policy == POL_OFF && m != longint'(LEVEL_ONE))
				r.st = STAT_MIX_OFF;
			else if (m == 0)
				y = longint'(dry);
			else if (m == longint'(LEVEL_ONE))
				y = longint'(wet);
			else if (policy != POL_EXACT || frames != dry_frames)
				r.st = STAT_LEN_MISMATCH;
			else begin
				s = longint'(dry) * (longint'(LEVEL_ONE) - m) + longint'(wet) * m;
				y = sat16((s + 32768) >>> 16);
			end
			// head and tail crossfade
			if (r.st == STAT_OK && m > 0 && frames >= 24'd2) begin
				f = longint'(rate / 1000);
				if (f < MIN_FADE)
					f = MIN_FADE;
				if (f > FADE_CAP)
					f = FADE_CAP;
				if (f > longint'(frames / 2))
					f = longint'(frames / 2);
				if (edges[0] && longint'(idx) < f)
					y = edge_fade(longint'(head), y, longint'(idx), f);
				if (edges[1] && idx < frames) begin
					k = longint'(frames) - 1 - longint'(idx);
					if (k < f)
						y = edge_fade(longint'(tail), y, k, f);
				end
			end
			r.sample = y[15:0];
			return r;
		endfunction

		function void note_request(logic signed [15:0] dry, logic signed [15:0] wet,
				logic [23:0] idx);
			expected_mix.push_back(mix_splice(dry, wet, idx));
		endfunction

		function void check_result(logic signed [15:0] sample, logic [1:0] st);
			mix_result_t e;
			if (expected_mix.size() == 0) begin
				errors++;
				$display("%0t: unexpected result sample %0d status %0d", $time, sample, st);
				return;
			end
			e = expected_mix.pop_front();
			if (sample !== e.sample) begin
				errors++;
				$display("%0t: out_sample expected %0d actual %0d", $time, e.sample, sample);
			end
			if (st !== 2'(e.st)) begin
				errors++;
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
			end
		endfunction

		function int pending();
			return expected_mix.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                item_valid = 1'b0;
	logic                item_ready;
	logic signed [15:0]  dry_sample = '0;
	logic signed [15:0]  wet_sample = '0;
	logic [23:0]         frame_index = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic signed [15:0]  out_sample;
	logic [1:0]          status;

	splice_scoreboard sb = new();

	// traffic shaping; calm is shared by both sides
	logic calm = 1'b0;
	logic hold_req = 1'b0;
	int   hold_cnt = 0;
	int   ready_roll;
	int   idle_cycles = 0;

	dry_wet_mix_edge_splice_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.dry_sample   (dry_sample),
		.wet_sample   (wet_sample),
		.frame_index  (frame_index),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_sample   (out_sample),
		.status       (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side backpressure
	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			result_ready <= 1'b0;
		end else if (calm) begin
			result_ready <= 1'b1;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 10)
				hold_cnt = $urandom_range(1, 3);
			else if (ready_roll < 12)
				hold_cnt = $urandom_range(10, 40);
			result_ready <= (ready_roll >= 12);
		end
	end

	// result compare
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(out_sample, status);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic apb_write(reg_idx_t r, logic [31:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.write_reg(r, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_drain();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// drain, then load every register
	task automatic configure(logic [16:0] level, logic [1:0] policy, logic [23:0] frames,
			logic [23:0] dframes, logic [18:0] rate, logic [1:0] edges,
			logic [15:0] head, logic [15:0] tail);
		wait_drain();
		apb_write(REG_MIX_LEVEL, 32'(level));
		apb_write(REG_MIX_POLICY, 32'(policy));
		apb_write(REG_FRAME_COUNT, 32'(frames));
		apb_write(REG_DRY_FRAME_COUNT, 32'(dframes));
		apb_write(REG_FS_HZ, 32'(rate));
		apb_write(REG_SPLICE_EDGES, 32'(edges));
		apb_write(REG_HEAD_EDGE, 32'(head));
		apb_write(REG_TAIL_EDGE, 32'(tail));
	endtask

	task automatic send_request(logic [15:0] dry, logic [15:0] wet, logic [23:0] idx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid  <= 1'b1;
		dry_sample  <= dry;
		wet_sample  <= wet;
		frame_index <= idx;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.note_request(dry, wet, idx);
	endtask

	task automatic stop_requests();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	// one random register setting and a burst of requests aimed at the fade zones
	task automatic random_phase(int n, bit squeeze);
		logic [23:0] frames;
		logic [23:0] dframes;
		logic [23:0] idx;
		logic [16:0] level;
		logic [1:0]  policy;
		logic [18:0] rate;
		int          roll;
		case ($urandom_range(0, 9))
			0:       frames = 24'($urandom_range(0, 1));
			1:       frames = 24'($urandom);
			2:       frames = 24'($urandom_range(2, 16));
			default: frames = 24'($urandom_range(17, 200));
		endcase
		case ($urandom_range(0, 7))
			0:       dframes = 24'($urandom);
			1:       dframes = frames + 24'd1;
			default: dframes = frames;
		endcase
		case ($urandom_range(0, 7))
			0:       level = '0;
			1:       level = LEVEL_ONE;
			2:       level = 17'($urandom_range(65537, 131071));
			default: level = 17'($urandom_range(1, 65535));
		endcase
		policy = ($urandom_range(0, 7) < 6) ? POL_EXACT : 2'($urandom_range(0, 3));
		case ($urandom_range(0, 5))
			0:       rate = 19'($urandom_range(0, 7999));
			1:       rate = 19'($urandom_range(64000, 524287));
			default: rate = 19'($urandom_range(8000, 63999));
		endcase
		configure(level, policy, frames, dframes, rate,
			$urandom_range(0, 1) ? 2'b11 : 2'($urandom_range(0, 3)),
			16'($urandom), 16'($urandom));
		if (squeeze)
			hold_req = 1'b1;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 9);
			if (roll < 4)
				idx = 24'($urandom_range(0, 70));
			else if (roll < 8)
				idx = frames - 24'($urandom_range(1, 70));
			else if (roll < 9)
				idx = frames + 24'($urandom_range(0, 3));
			else
				idx = 24'($urandom);
			send_request(16'($urandom), 16'($urandom), idx);
		end
		stop_requests();
	endtask

	initial begin
		int sent;
		int n;
		int phase;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: full wet, no splice
		send_request(16'sh7FFF, 16'sh8000, 24'd0);
		send_request(16'sh8000, 16'sh7FFF, 24'hFFFFFF);
		send_request(16'sh1234, 16'sh8001, 24'd5);
		stop_requests();

		// mix disabled with a partial level
		configure(17'd32768, POL_OFF, 24'd16, 24'd16, 19'd48000, 2'b11, 16'h7FFF, 16'h8000);
		send_request(16'sh7FFF, 16'sh7FFF, 24'd0);
		send_request(16'sh8000, 16'sh0001, 24'd3);
		stop_requests();

		// level zero passes dry, no splice
		configure(17'd0, POL_EXACT, 24'd16, 24'd16, 19'd48000, 2'b11, 16'h7FFF, 16'h8000);
		send_request(16'sh8000, 16'sh7FFF, 24'd0);
		send_request(16'sh7FFF, 16'sh8000, 24'd15);
		stop_requests();

		// level above one saturates to full wet; fade of 8 at both ends
		configure(17'h1FFFF, POL_EXACT, 24'd16, 24'd16, 19'd48000, 2'b11, 16'h7FFF, 16'h8000);
		send_request(16'sh0000, 16'sh8000, 24'd0);
		send_request(16'sh0000, 16'sh8000, 24'd7);
		send_request(16'sh0000, 16'sh7FFF, 24'd8);
		send_request(16'sh0000, 16'sh7FFF, 24'd15);
		send_request(16'sh0000, 16'sh7FFF, 24'd16);
		send_request(16'sh0000, 16'sh7FFF, 24'hFFFFFF);
		stop_requests();

		// half mix, top rate, fade clamped to half the frames; rounding ties
		configure(17'd32768, POL_EXACT, 24'd100, 24'd100, 19'h7FFFF, 2'b11,
			16'h8000, 16'h7FFF);
		send_request(16'sh7FFF, 16'sh7FFF, 24'd0);
		send_request(16'sh8000, 16'sh8000, 24'd99);
		send_request(16'sh0100, 16'sh0200, 24'd49);
		send_request(16'sh0100, 16'sh0200, 24'd50);
		send_request(16'sh0001, 16'sh0000, 24'd30);
		send_request(16'shFFFF, 16'sh0000, 24'd30);
		stop_requests();

		// partial mix refused: length mismatch, policy 2, unused policy
		configure(17'd1000, POL_EXACT, 24'd100, 24'd99, 19'd0, 2'b11, 16'h0000, 16'h0000);
		send_request(16'sh1000, 16'sh2000, 24'd0);
		stop_requests();
		configure(17'd1000, 2'd2, 24'd100, 24'd100, 19'd0, 2'b11, 16'h0000, 16'h0000);
		send_request(16'sh1000, 16'sh2000, 24'd0);
		stop_requests();
		configure(17'd1000, 2'd3, 24'd100, 24'd100, 19'd0, 2'b11, 16'h0000, 16'h0000);
		send_request(16'sh1000, 16'sh2000, 24'd0);
		stop_requests();

		// one frame: no splice; two frames: fade of one
		configure(LEVEL_ONE, POL_EXACT, 24'd1, 24'd1, 19'd0, 2'b11, 16'h7FFF, 16'h8000);
		send_request(16'sh0000, 16'sh4000, 24'd0);
		stop_requests();
		configure(LEVEL_ONE, POL_EXACT, 24'd2, 24'd2, 19'd0, 2'b11, 16'h7FFF, 16'h8000);
		send_request(16'sh0000, 16'sh4000, 24'd0);
		send_request(16'sh0000, 16'sh4000, 24'd1);
		stop_requests();

		// random register settings, each followed by a burst
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			n    = $urandom_range(20, 80);
			calm = ($urandom_range(0, 4) == 0);
			if (phase == 2) begin
				calm = 1'b1;
				n    = 60;
			end
			random_phase(n, phase == 2);
			sent += n;
			phase++;
		end
		calm = 1'b0;

		wait_drain();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/dwmes_pkg.sv
hw/rtl/dry_wet_mix_edge_splice_core.sv
tb/tb_top.sv
